// ===== hdl/conductance_lif_neuron_step_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the conductance LIF neuron step block.
// They expect clk_i and rst_ni in the scope of use.
// ---------------------------------------------------------------------------
`ifndef CONDUCTANCE_LIF_NEURON_STEP_DEFINES_SVH
`define CONDUCTANCE_LIF_NEURON_STEP_DEFINES_SVH

// Generic clocked check, disabled while reset is asserted.
`define CLIF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define CLIF_ASSERT_IMPL(lbl, ante, cons, msg) \
  `CLIF_ASSERT(lbl, (ante) |-> (cons), msg)

// Next-cycle implication.
`define CLIF_ASSERT_NEXT(lbl, ante, cons, msg) \
  `CLIF_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ===== hdl/clif_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// clif_pkg
// Types and constants shared by the conductance LIF neuron step block.
// ---------------------------------------------------------------------------
package clif_pkg;

  localparam int WORD_W = 40;
  localparam int FRAC_W = 24;
  localparam int GAIN_W = 25;
  localparam int REFR_W = 8;
  localparam int CFG_IDX_W = 3;

  localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  localparam logic signed [WORD_W-1:0] V_REST     = WORD_W'(-60 * (2 ** FRAC_W));
  localparam logic signed [WORD_W-1:0] V_INHIB    = WORD_W'(-80 * (2 ** FRAC_W));
  localparam logic signed [WORD_W-1:0] THR_BASE   = WORD_W'(-50 * (2 ** FRAC_W));
  localparam logic signed [WORD_W-1:0] THR_SPIKE  = WORD_W'(50 * (2 ** FRAC_W));
  localparam logic signed [WORD_W-1:0] ONE_FX     = WORD_W'(2 ** FRAC_W);
  localparam logic signed [WORD_W-1:0] USE_FX     = WORD_W'(((2 ** FRAC_W) + 2) / 5);
  localparam logic [GAIN_W-1:0]        GAIN_ONE   = GAIN_W'(2 ** FRAC_W);

  // Q0.32 decay factors.
  localparam logic [31:0] K_AMPA  = 32'd4209921245;
  localparam logic [31:0] K_GABA  = 32'd4252231657;
  localparam logic [31:0] K_X     = 32'd4292820349;
  localparam logic [31:0] K_U     = 32'd4294251528;
  localparam logic [31:0] K_TRACE = 32'd4273546057;
  localparam logic [31:0] K_THR   = 32'd4085499269;

  // ceil(2^56 / 100000); exact floor division for magnitudes up to 2^39.
  localparam logic [39:0] RECIP_ACT = 40'd720575940380;

  localparam logic [GAIN_W-1:0]        EXCIT_MIX_RST = 25'd3355443;
  localparam logic signed [WORD_W-1:0] BIAS_RST      = '0;
  localparam logic [REFR_W-1:0]        REFR_TICKS_RST = 8'd10;
  localparam logic [GAIN_W-1:0]        MEMB_GAIN_RST = 25'd83886;
  localparam logic [GAIN_W-1:0]        NMDA_GAIN_RST = 25'd16777;

  typedef enum logic [1:0] {
    REQ_TICK    = 2'd0,
    REQ_EXCIT   = 2'd1,
    REQ_INHIB   = 2'd2,
    REQ_SILENCE = 2'd3
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EXCIT_MIX  = 3'd0,
    CFG_BIAS       = 3'd1,
    CFG_REFR_TICKS = 3'd2,
    CFG_MEMB_GAIN  = 3'd3,
    CFG_NMDA_GAIN  = 3'd4
  } cfg_idx_e;

  // One multiply-and-update step of a tick, in execution order.
  typedef enum logic [3:0] {
    OP_GEX_A, OP_GEX_N, OP_DRV_EX, OP_DRV_IN, OP_MEMB,
    OP_NMDA, OP_AMPA, OP_GABA, OP_THR,
    OP_STP_UX, OP_STP_UC, OP_STP_X, OP_STP_U, OP_TRACE, OP_ACT
  } op_e;

  typedef enum logic [1:0] {
    SH_FRAC,   // >> FRAC_W, rounded
    SH_K,      // >> 32, rounded
    SH_RECIP   // >> 56, truncated
  } shift_e;

  typedef enum logic [1:0] {
    MUL_IDLE, MUL_LO, MUL_HI, MUL_FIN
  } mul_phase_e;

  typedef enum logic [2:0] {
    CS_IDLE, CS_DECODE, CS_LAUNCH, CS_WAIT, CS_FINISH
  } ctrl_state_e;

  typedef struct packed {
    logic [1:0]               req_type;
    logic signed [WORD_W-1:0] weight;
  } in_item_t;

  typedef struct packed {
    logic                     spiked;
    logic signed [WORD_W-1:0] voltage;
    logic signed [WORD_W-1:0] threshold;
    logic signed [WORD_W-1:0] activity_level;
    logic signed [WORD_W-1:0] spike_trace;
    logic signed [WORD_W-1:0] stp_resource;
    logic signed [WORD_W-1:0] stp_use;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic apply;
    logic refr_dec;
    logic start;
    logic commit;
    op_e  op;
  } ctrl_cmd_t;

  typedef struct packed {
    req_e req;
    logic silenced;
    logic refr_zero;
    logic mul_done;
  } dp_status_t;

endpackage

// ===== hdl/conductance_lif_neuron_step.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// conductance_lif_neuron_step
// Conductance-based leaky integrate-and-fire neuron, one step per transaction.
// ---------------------------------------------------------------------------
//  Channel  Direction  Handshake                Payload
//  in       input      in_valid_i / in_ready_o  in_i (req_type, weight)
//  out      output     out_valid_o / out_ready_i out_o (spiked, state words)
//  cfg      input      cfg_we_i                 cfg_idx_i, cfg_data_i
//
// A tick runs 15 multiply steps on one shared multiplier; a refractory tick
// skips the integration steps and starts at the NMDA step. An injection,
// silence or silenced tick runs no multiply step.
// One transaction is in flight; the next is accepted while a result waits.
// Reset loads the rest state and register defaults at once.
// ---------------------------------------------------------------------------
`include "conductance_lif_neuron_step_defines.svh"

module conductance_lif_neuron_step (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  clif_pkg::in_item_t             in_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output clif_pkg::out_item_t            out_o,
  input  logic                           cfg_we_i,
  input  logic [clif_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [clif_pkg::WORD_W-1:0]    cfg_data_i
);

  clif_pkg::ctrl_cmd_t  cmd;
  clif_pkg::dp_status_t status;
  clif_pkg::out_item_t  result;
  clif_pkg::out_item_t  out_q;
  logic                 out_valid_q, out_valid_d;
  logic                 load_out;

  clif_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .out_hold_i(out_valid_q && !out_ready_i),
    .load_out_o(load_out),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  clif_dpath u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .status_o  (status),
    .in_i      (in_i),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .result_o  (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) out_q <= result;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `CLIF_ASSERT_IMPL(a_no_overwrite, load_out && out_valid_q, out_ready_i, "result overwritten")
  `CLIF_ASSERT_NEXT(a_one_in_flight, in_valid_i && in_ready_o, !in_ready_o, "second transaction taken")
  `CLIF_ASSERT(a_load_not_idle, !(load_out && in_ready_o), "result loaded while idle")

endmodule

// ===== hdl/clif_mul.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// clif_mul
// Sequential signed fixed-point multiplier: 40x20 partial products in the
// MUL_LO and MUL_HI phases, then round or truncate, shift and saturate.
// ---------------------------------------------------------------------------
module clif_mul (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [clif_pkg::WORD_W-1:0] a_i,
  input  logic signed [clif_pkg::WORD_W:0]   b_i,
  input  clif_pkg::shift_e                  mode_i,
  output logic                              done_o,
  output logic signed [clif_pkg::WORD_W-1:0] p_o
);

  localparam int W  = clif_pkg::WORD_W;
  localparam int HW = W / 2;
  localparam int PW = 2 * W;

  clif_pkg::mul_phase_e phase_q, phase_d;
  logic [W-1:0]   mag_a_q, mag_b_q;
  logic           neg_q;
  clif_pkg::shift_e mode_q;
  logic [PW-1:0]  acc_q, acc_d;
  logic           done_q, done_d;
  logic signed [W-1:0] p_q, p_d;

  logic [W:0]     abs_a, abs_b;
  logic [HW-1:0]  half_b;
  logic [W+HW-1:0] pp;
  logic [PW:0]    rnd, sum, quo;
  logic [PW:0]    lim;

  assign abs_a  = a_i[W-1] ? -{a_i[W-1], a_i} : {a_i[W-1], a_i};
  assign abs_b  = b_i[W] ? -b_i : b_i;
  assign half_b = (phase_q == clif_pkg::MUL_LO) ? mag_b_q[HW-1:0] : mag_b_q[W-1:HW];
  assign pp     = mag_a_q * half_b;

  always_comb begin
    case (mode_q)
      clif_pkg::SH_FRAC: rnd = (PW+1)'(1) << (clif_pkg::FRAC_W - 1);
      clif_pkg::SH_K:    rnd = (PW+1)'(1) << 31;
      default:           rnd = '0;
    endcase
    sum = {1'b0, acc_q} + rnd;
    case (mode_q)
      clif_pkg::SH_FRAC: quo = sum >> clif_pkg::FRAC_W;
      clif_pkg::SH_K:    quo = sum >> 32;
      default:           quo = sum >> 56;
    endcase
    lim = neg_q ? ((PW+1)'(1) << (W - 1)) : (((PW+1)'(1) << (W - 1)) - 1'b1);
  end

  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    done_d  = 1'b0;
    p_d     = p_q;
    case (phase_q)
      clif_pkg::MUL_IDLE: begin
        if (start_i) phase_d = clif_pkg::MUL_LO;
      end
      clif_pkg::MUL_LO: begin
        acc_d   = {{(PW-W-HW){1'b0}}, pp};
        phase_d = clif_pkg::MUL_HI;
      end
      clif_pkg::MUL_HI: begin
        acc_d   = acc_q + {pp, {HW{1'b0}}};
        phase_d = clif_pkg::MUL_FIN;
      end
      clif_pkg::MUL_FIN: begin
        if (quo > lim) begin
          p_d = neg_q ? clif_pkg::WORD_MIN : clif_pkg::WORD_MAX;
        end else if (neg_q) begin
          p_d = -quo[W-1:0];
        end else begin
          p_d = quo[W-1:0];
        end
        done_d  = 1'b1;
        phase_d = clif_pkg::MUL_IDLE;
      end
      default: phase_d = clif_pkg::MUL_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= clif_pkg::MUL_IDLE;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (phase_q == clif_pkg::MUL_IDLE && start_i) begin
      mag_a_q <= abs_a[W-1:0];
      mag_b_q <= abs_b[W-1:0];
      neg_q   <= a_i[W-1] ^ b_i[W];
      mode_q  <= mode_i;
    end
    acc_q <= acc_d;
    p_q   <= p_d;
  end

  assign done_o = done_q;
  assign p_o    = p_q;

endmodule

// ===== hdl/clif_dpath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// clif_dpath
// Neuron state, configuration registers, operand selection for the shared
// multiplier and write-back of each step.
// ---------------------------------------------------------------------------
module clif_dpath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  clif_pkg::ctrl_cmd_t                 cmd_i,
  output clif_pkg::dp_status_t                status_o,
  input  clif_pkg::in_item_t                  in_i,
  input  logic                                cfg_we_i,
  input  logic [clif_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [clif_pkg::WORD_W-1:0]         cfg_data_i,
  output clif_pkg::out_item_t                 result_o
);

  localparam int W = clif_pkg::WORD_W;
  localparam int G = clif_pkg::GAIN_W;

  function automatic logic signed [W-1:0] sadd(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    logic signed [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) return s[W] ? clif_pkg::WORD_MIN : clif_pkg::WORD_MAX;
    return s[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] ssub(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    logic signed [W:0] s;
    s = {a[W-1], a} - {b[W-1], b};
    if (s[W] != s[W-1]) return s[W] ? clif_pkg::WORD_MIN : clif_pkg::WORD_MAX;
    return s[W-1:0];
  endfunction

  function automatic logic [G-1:0] capgain(input logic [G-1:0] g);
    return g[G-1] ? clif_pkg::GAIN_ONE : g;
  endfunction

  // Configuration.
  logic [G-1:0]                    excit_mix_q, memb_gain_q, nmda_gain_q;
  logic signed [W-1:0]             bias_q;
  logic [clif_pkg::REFR_W-1:0]     refr_ticks_q;

  // Neuron state.
  logic signed [W-1:0] memb_q, memb_d, thr_q, thr_d, ga_q, ga_d, gn_q, gn_d;
  logic signed [W-1:0] gi_q, gi_d, x_q, x_d, u_q, u_d, trace_q, trace_d;
  logic signed [W-1:0] act_q, act_d;
  logic [clif_pkg::REFR_W-1:0] refr_q, refr_d;
  logic silenced_q, silenced_d, fired_q, fired_d;

  // Transaction and scratch.
  clif_pkg::req_e       req_q;
  logic signed [W-1:0]  weight_q;
  logic signed [W-1:0]  tmp_a_q, tmp_a_d, tmp_d_q, tmp_d_d;

  // Multiplier.
  logic signed [W-1:0]  mul_a;
  logic signed [W:0]    mul_b;
  clif_pkg::shift_e     mul_mode;
  logic                 mul_done;
  logic signed [W-1:0]  mul_p;

  logic [G-1:0]         alpha;
  logic signed [W-1:0]  vnew, t_op, t_wb;

  clif_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .mode_i (mul_mode),
    .done_o (mul_done),
    .p_o    (mul_p)
  );

  assign alpha = capgain(excit_mix_q);

  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    mul_mode = clif_pkg::SH_FRAC;
    t_op     = '0;
    case (cmd_i.op)
      clif_pkg::OP_GEX_A: begin
        mul_a = ga_q;
        mul_b = (W+1)'(alpha);
      end
      clif_pkg::OP_GEX_N: begin
        mul_a = gn_q;
        mul_b = (W+1)'(clif_pkg::GAIN_ONE - alpha);
      end
      clif_pkg::OP_DRV_EX: begin
        t_op  = ssub('0, memb_q);
        mul_a = tmp_a_q;
        mul_b = {t_op[W-1], t_op};
      end
      clif_pkg::OP_DRV_IN: begin
        t_op  = ssub(clif_pkg::V_INHIB, memb_q);
        mul_a = gi_q;
        mul_b = {t_op[W-1], t_op};
      end
      clif_pkg::OP_MEMB: begin
        mul_a = tmp_d_q;
        mul_b = (W+1)'(capgain(memb_gain_q));
      end
      clif_pkg::OP_NMDA: begin
        mul_a = ssub(ga_q, gn_q);
        mul_b = (W+1)'(capgain(nmda_gain_q));
      end
      clif_pkg::OP_AMPA: begin
        mul_a    = ga_q;
        mul_b    = (W+1)'(clif_pkg::K_AMPA);
        mul_mode = clif_pkg::SH_K;
      end
      clif_pkg::OP_GABA: begin
        mul_a    = gi_q;
        mul_b    = (W+1)'(clif_pkg::K_GABA);
        mul_mode = clif_pkg::SH_K;
      end
      clif_pkg::OP_THR: begin
        mul_a    = ssub(thr_q, clif_pkg::THR_BASE);
        mul_b    = (W+1)'(clif_pkg::K_THR);
        mul_mode = clif_pkg::SH_K;
      end
      clif_pkg::OP_STP_UX: begin
        mul_a = u_q;
        mul_b = {x_q[W-1], x_q};
      end
      clif_pkg::OP_STP_UC: begin
        t_op  = ssub(clif_pkg::ONE_FX, u_q);
        mul_a = clif_pkg::USE_FX;
        mul_b = {t_op[W-1], t_op};
      end
      clif_pkg::OP_STP_X: begin
        mul_a    = ssub(clif_pkg::ONE_FX, x_q);
        mul_b    = (W+1)'(clif_pkg::K_X);
        mul_mode = clif_pkg::SH_K;
      end
      clif_pkg::OP_STP_U: begin
        mul_a    = ssub(clif_pkg::USE_FX, u_q);
        mul_b    = (W+1)'(clif_pkg::K_U);
        mul_mode = clif_pkg::SH_K;
      end
      clif_pkg::OP_TRACE: begin
        mul_a    = trace_q;
        mul_b    = (W+1)'(clif_pkg::K_TRACE);
        mul_mode = clif_pkg::SH_K;
      end
      clif_pkg::OP_ACT: begin
        mul_a    = act_q;
        mul_b    = (W+1)'(clif_pkg::RECIP_ACT);
        mul_mode = clif_pkg::SH_RECIP;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  always_comb begin
    memb_d     = memb_q;
    thr_d      = thr_q;
    ga_d       = ga_q;
    gn_d       = gn_q;
    gi_d       = gi_q;
    x_d        = x_q;
    u_d        = u_q;
    trace_d    = trace_q;
    act_d      = act_q;
    refr_d     = refr_q;
    silenced_d = silenced_q;
    fired_d    = fired_q;
    tmp_a_d    = tmp_a_q;
    tmp_d_d    = tmp_d_q;
    t_wb       = '0;
    vnew       = sadd(memb_q, mul_p);

    if (cmd_i.capture) fired_d = 1'b0;
    if (cmd_i.refr_dec) refr_d = refr_q - 1'b1;

    if (cmd_i.apply) begin
      case (req_q)
        clif_pkg::REQ_EXCIT:   if (refr_q == '0) ga_d = sadd(ga_q, weight_q);
        clif_pkg::REQ_INHIB:   if (refr_q == '0) gi_d = sadd(gi_q, weight_q);
        clif_pkg::REQ_SILENCE: silenced_d = 1'b1;
        default:               silenced_d = silenced_q;
      endcase
    end

    if (cmd_i.commit) begin
      case (cmd_i.op)
        clif_pkg::OP_GEX_A: tmp_a_d = mul_p;
        clif_pkg::OP_GEX_N: begin
          tmp_a_d = sadd(tmp_a_q, mul_p);
          tmp_d_d = ssub(clif_pkg::V_REST, memb_q);
        end
        clif_pkg::OP_DRV_EX: tmp_d_d = sadd(tmp_d_q, mul_p);
        clif_pkg::OP_DRV_IN: tmp_d_d = sadd(sadd(tmp_d_q, mul_p), bias_q);
        clif_pkg::OP_MEMB: begin
          if (vnew > thr_q) begin
            refr_d  = refr_ticks_q;
            thr_d   = clif_pkg::THR_SPIKE;
            memb_d  = clif_pkg::V_REST;
            fired_d = 1'b1;
          end else begin
            memb_d = vnew;
          end
        end
        clif_pkg::OP_NMDA:   gn_d = sadd(gn_q, mul_p);
        clif_pkg::OP_AMPA:   ga_d = mul_p;
        clif_pkg::OP_GABA:   gi_d = mul_p;
        clif_pkg::OP_THR:    thr_d = sadd(clif_pkg::THR_BASE, mul_p);
        clif_pkg::OP_STP_UX: tmp_a_d = mul_p;
        clif_pkg::OP_STP_UC: tmp_d_d = mul_p;
        clif_pkg::OP_STP_X: begin
          t_wb = ssub(clif_pkg::ONE_FX, mul_p);
          x_d  = fired_q ? ssub(t_wb, tmp_a_q) : t_wb;
        end
        clif_pkg::OP_STP_U: begin
          t_wb = ssub(clif_pkg::USE_FX, mul_p);
          u_d  = fired_q ? sadd(t_wb, tmp_d_q) : t_wb;
        end
        clif_pkg::OP_TRACE: trace_d = fired_q ? sadd(mul_p, clif_pkg::ONE_FX) : mul_p;
        clif_pkg::OP_ACT: begin
          t_wb  = ssub(act_q, mul_p);
          act_d = fired_q ? sadd(t_wb, clif_pkg::ONE_FX) : t_wb;
        end
        default: tmp_a_d = tmp_a_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      excit_mix_q  <= clif_pkg::EXCIT_MIX_RST;
      bias_q       <= clif_pkg::BIAS_RST;
      refr_ticks_q <= clif_pkg::REFR_TICKS_RST;
      memb_gain_q  <= clif_pkg::MEMB_GAIN_RST;
      nmda_gain_q  <= clif_pkg::NMDA_GAIN_RST;
      memb_q       <= clif_pkg::V_REST;
      thr_q        <= clif_pkg::THR_BASE;
      ga_q         <= '0;
      gn_q         <= '0;
      gi_q         <= '0;
      x_q          <= clif_pkg::ONE_FX;
      u_q          <= clif_pkg::USE_FX;
      trace_q      <= '0;
      act_q        <= '0;
      refr_q       <= '0;
      silenced_q   <= 1'b0;
      fired_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (clif_pkg::cfg_idx_e'(cfg_idx_i))
          clif_pkg::CFG_EXCIT_MIX:  excit_mix_q  <= cfg_data_i[G-1:0];
          clif_pkg::CFG_BIAS:       bias_q       <= cfg_data_i;
          clif_pkg::CFG_REFR_TICKS: refr_ticks_q <= cfg_data_i[clif_pkg::REFR_W-1:0];
          clif_pkg::CFG_MEMB_GAIN:  memb_gain_q  <= cfg_data_i[G-1:0];
          clif_pkg::CFG_NMDA_GAIN:  nmda_gain_q  <= cfg_data_i[G-1:0];
          default:                  bias_q       <= bias_q;
        endcase
      end
      memb_q     <= memb_d;
      thr_q      <= thr_d;
      ga_q       <= ga_d;
      gn_q       <= gn_d;
      gi_q       <= gi_d;
      x_q        <= x_d;
      u_q        <= u_d;
      trace_q    <= trace_d;
      act_q      <= act_d;
      refr_q     <= refr_d;
      silenced_q <= silenced_d;
      fired_q    <= fired_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q    <= clif_pkg::req_e'(in_i.req_type);
      weight_q <= in_i.weight;
    end
    tmp_a_q <= tmp_a_d;
    tmp_d_q <= tmp_d_d;
  end

  assign status_o.req       = req_q;
  assign status_o.silenced  = silenced_q;
  assign status_o.refr_zero = (refr_q == '0);
  assign status_o.mul_done  = mul_done;

  assign result_o.spiked         = fired_q;
  assign result_o.voltage        = memb_q;
  assign result_o.threshold      = thr_q;
  assign result_o.activity_level = act_q;
  assign result_o.spike_trace    = trace_q;
  assign result_o.stp_resource   = x_q;
  assign result_o.stp_use        = u_q;

endmodule

// ===== hdl/clif_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// clif_ctrl
// Sequencer: takes a transaction, steps through the multiply steps of a tick
// and hands the result to the output register.
// ---------------------------------------------------------------------------
module clif_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 out_hold_i,
  output logic                 load_out_o,
  input  clif_pkg::dp_status_t status_i,
  output clif_pkg::ctrl_cmd_t  cmd_o
);

  clif_pkg::ctrl_state_e state_q, state_d;
  clif_pkg::op_e         op_q, op_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= clif_pkg::CS_IDLE;
      op_q    <= clif_pkg::OP_GEX_A;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    in_ready_o = 1'b0;
    load_out_o = 1'b0;
    cmd_o      = '0;
    cmd_o.op   = op_q;
    case (state_q)
      clif_pkg::CS_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = clif_pkg::CS_DECODE;
        end
      end
      clif_pkg::CS_DECODE: begin
        if (status_i.req == clif_pkg::REQ_TICK) begin
          if (status_i.silenced) begin
            state_d = clif_pkg::CS_FINISH;
          end else if (status_i.refr_zero) begin
            op_d    = clif_pkg::OP_GEX_A;
            state_d = clif_pkg::CS_LAUNCH;
          end else begin
            // Refractory: skip integration and go straight to the decays.
            cmd_o.refr_dec = 1'b1;
            op_d           = clif_pkg::OP_NMDA;
            state_d        = clif_pkg::CS_LAUNCH;
          end
        end else begin
          cmd_o.apply = 1'b1;
          state_d     = clif_pkg::CS_FINISH;
        end
      end
      clif_pkg::CS_LAUNCH: begin
        cmd_o.start = 1'b1;
        state_d     = clif_pkg::CS_WAIT;
      end
      clif_pkg::CS_WAIT: begin
        if (status_i.mul_done) begin
          cmd_o.commit = 1'b1;
          if (op_q == clif_pkg::OP_ACT) begin
            state_d = clif_pkg::CS_FINISH;
          end else begin
            op_d    = clif_pkg::op_e'(op_q + 1'b1);
            state_d = clif_pkg::CS_LAUNCH;
          end
        end
      end
      clif_pkg::CS_FINISH: begin
        if (!out_hold_i) begin
          load_out_o = 1'b1;
          state_d    = clif_pkg::CS_IDLE;
        end
      end
      default: state_d = clif_pkg::CS_IDLE;
    endcase
  end

endmodule

// ===== sim/conductance_lif_neuron_step_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// conductance_lif_neuron_step_checker
// Watches the input, output and register ports of the neuron step block.
// It keeps its own copy of the neuron state and predicts each result.
// ---------------------------------------------------------------------------
module conductance_lif_neuron_step_checker
  import clif_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  in_item_t             in_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  out_item_t            out_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [WORD_W-1:0]    cfg_data_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  localparam longint WMAX = longint'(WORD_MAX);
  localparam longint WMIN = longint'(WORD_MIN);
  localparam longint GONE = 64'd16777216;

  // Register copies.
  longint mix_q, bias_q, memb_gain_q, nmda_gain_q;
  int unsigned refr_ticks_q;

  // Neuron state copies.
  longint memb_q, thr_q, g_ampa_q, g_nmda_q, g_gaba_q;
  longint res_x_q, use_u_q, trace_q, act_q;
  int unsigned refr_cnt_q;
  logic silenced_q;

  out_item_t step_results_q[$];

  function automatic longint sat_word(longint v);
    if (v > WMAX) return WMAX;
    if (v < WMIN) return WMIN;
    return v;
  endfunction

  function automatic longint sat_add(longint a, longint b);
    return sat_word(a + b);
  endfunction

  function automatic longint sat_sub(longint a, longint b);
    return sat_word(a - b);
  endfunction

  // Product shifted right by s, rounded half away from zero, saturated.
  function automatic longint mul_round(longint a, longint b, int s);
    logic neg;
    logic [63:0] ua, ub;
    logic [127:0] p, lim;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    p = {64'd0, ua} * {64'd0, ub};
    p = (p + (128'd1 << (s - 1))) >> s;
    lim = neg ? (128'd1 << 39) : ((128'd1 << 39) - 1);
    if (p > lim) return neg ? WMIN : WMAX;
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic longint cap_gain(longint g);
    return (g > GONE) ? GONE : g;
  endfunction

  function automatic longint kq32(logic [31:0] k);
    return longint'({32'd0, k});
  endfunction

  // Advances the neuron by one simulation tick; returns 1 on a spike.
  function automatic logic neuron_tick();
    longint v, u_old, x_old, one, uc, al, gex, drv;
    logic fired;
    fired = 1'b0;
    v = memb_q;
    u_old = use_u_q;
    x_old = res_x_q;
    one = longint'(ONE_FX);
    uc = longint'(USE_FX);
    if (refr_cnt_q == 0) begin
      al = cap_gain(mix_q);
      gex = sat_add(mul_round(g_ampa_q, al, 24), mul_round(g_nmda_q, GONE - al, 24));
      drv = sat_sub(longint'(V_REST), v);
      drv = sat_add(drv, mul_round(gex, sat_sub(0, v), FRAC_W));
      drv = sat_add(drv, mul_round(g_gaba_q, sat_sub(longint'(V_INHIB), v), FRAC_W));
      drv = sat_add(drv, bias_q);
      v = sat_add(v, mul_round(drv, cap_gain(memb_gain_q), 24));
      memb_q = v;
      if (v > thr_q) begin
        refr_cnt_q = refr_ticks_q;
        thr_q = longint'(THR_SPIKE);
        memb_q = longint'(V_REST);
        fired = 1'b1;
      end
    end else begin
      refr_cnt_q--;
    end
    // NMDA relaxes toward the AMPA value from before its own decay.
    g_nmda_q = sat_add(g_nmda_q,
                       mul_round(sat_sub(g_ampa_q, g_nmda_q), cap_gain(nmda_gain_q), 24));
    g_ampa_q = mul_round(g_ampa_q, kq32(K_AMPA), 32);
    g_gaba_q = mul_round(g_gaba_q, kq32(K_GABA), 32);
    thr_q = sat_add(longint'(THR_BASE),
                    mul_round(sat_sub(thr_q, longint'(THR_BASE)), kq32(K_THR), 32));
    res_x_q = sat_sub(one, mul_round(sat_sub(one, x_old), kq32(K_X), 32));
    use_u_q = sat_sub(uc, mul_round(sat_sub(uc, u_old), kq32(K_U), 32));
    trace_q = mul_round(trace_q, kq32(K_TRACE), 32);
    act_q = sat_sub(act_q, act_q / 100000);
    if (fired) begin
      res_x_q = sat_sub(res_x_q, mul_round(u_old, x_old, FRAC_W));
      use_u_q = sat_add(use_u_q, mul_round(uc, sat_sub(one, u_old), FRAC_W));
      trace_q = sat_add(trace_q, one);
      act_q = sat_add(act_q, one);
    end
    return fired;
  endfunction

  function automatic out_item_t neuron_step(in_item_t it);
    out_item_t r;
    longint w;
    w = longint'(it.weight);
    r.spiked = 1'b0;
    case (req_e'(it.req_type))
      REQ_TICK:  if (!silenced_q) r.spiked = neuron_tick();
      REQ_EXCIT: if (refr_cnt_q == 0) g_ampa_q = sat_add(g_ampa_q, w);
      REQ_INHIB: if (refr_cnt_q == 0) g_gaba_q = sat_add(g_gaba_q, w);
      default:   silenced_q = 1'b1;
    endcase
    r.voltage        = memb_q[WORD_W-1:0];
    r.threshold      = thr_q[WORD_W-1:0];
    r.activity_level = act_q[WORD_W-1:0];
    r.spike_trace    = trace_q[WORD_W-1:0];
    r.stp_resource   = res_x_q[WORD_W-1:0];
    r.stp_use        = use_u_q[WORD_W-1:0];
    return r;
  endfunction

  assign pending_o = step_results_q.size();

  // The state copies are updated in place, so blocking assignments are used.
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_r;
    if (!rst_ni) begin
      mix_q        = longint'(EXCIT_MIX_RST);
      bias_q       = longint'(BIAS_RST);
      refr_ticks_q = {24'd0, REFR_TICKS_RST};
      memb_gain_q  = longint'(MEMB_GAIN_RST);
      nmda_gain_q  = longint'(NMDA_GAIN_RST);
      memb_q       = longint'(V_REST);
      thr_q        = longint'(THR_BASE);
      refr_cnt_q   = 0;
      g_ampa_q     = 0;
      g_nmda_q     = 0;
      g_gaba_q     = 0;
      res_x_q      = longint'(ONE_FX);
      use_u_q      = longint'(USE_FX);
      trace_q      = 0;
      act_q        = 0;
      silenced_q   = 1'b0;
      fail_count_o = 0;
      step_results_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_EXCIT_MIX:  mix_q = longint'({39'd0, cfg_data_i[GAIN_W-1:0]});
          CFG_BIAS:       bias_q = longint'($signed(cfg_data_i));
          CFG_REFR_TICKS: refr_ticks_q = {24'd0, cfg_data_i[REFR_W-1:0]};
          CFG_MEMB_GAIN:  memb_gain_q = longint'({39'd0, cfg_data_i[GAIN_W-1:0]});
          CFG_NMDA_GAIN:  nmda_gain_q = longint'({39'd0, cfg_data_i[GAIN_W-1:0]});
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (step_results_q.size() == 0) begin
          fail_count_o = fail_count_o + 1;
          if (fail_count_o <= 10) $display("Unexpected result transaction: %p", out_i);
        end else begin
          exp_r = step_results_q.pop_front();
          if (out_i !== exp_r) begin
            fail_count_o = fail_count_o + 1;
            if (fail_count_o <= 10) begin
              $display("Result mismatch at %0t", $realtime);
              $display("  expected: %p", exp_r);
              $display("  actual:   %p", out_i);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) step_results_q.push_back(neuron_step(in_i));
    end
  end

endmodule

// ===== sim/conductance_lif_neuron_step_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// conductance_lif_neuron_step_tb
// Drives ticks, injections and silence requests into the neuron step block
// under several register settings, with random idle cycles on both channels.
// ---------------------------------------------------------------------------
module conductance_lif_neuron_step_tb;
  import clif_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 120;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_item = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_item;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [WORD_W-1:0]    cfg_data = '0;
  logic                 idle_en = 1'b1;
  int                   fail_count, pending, stall_cycles = 0;

  always #6 clk = ~clk;

  conductance_lif_neuron_step u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_i(in_item),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_o(out_item),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  conductance_lif_neuron_step_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_i(in_item),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_i(out_item),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk) begin
    out_ready <= idle_en ? ($urandom_range(99) >= 16) : 1'b1;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("conductance_lif_neuron_step_tb failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Within send_item, valid is lowered only when an idle gap is taken, so
  // back-to-back transactions keep it high.
  task automatic send_item(req_e req, logic [WORD_W-1:0] w);
    if (idle_en && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 40);
    end
    in_valid <= 1'b1;
    in_item <= '{req_type: req, weight: w};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_block();
    if (in_valid) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(logic [24:0] mix, logic [WORD_W-1:0] bias,
                            logic [7:0] refr, logic [24:0] mgain, logic [24:0] ngain);
    drain_block();
    cfg_we <= 1'b1;
    cfg_idx <= CFG_EXCIT_MIX;  cfg_data <= WORD_W'(mix);   @(posedge clk);
    cfg_idx <= CFG_BIAS;       cfg_data <= bias;           @(posedge clk);
    cfg_idx <= CFG_REFR_TICKS; cfg_data <= WORD_W'(refr);  @(posedge clk);
    cfg_idx <= CFG_MEMB_GAIN;  cfg_data <= WORD_W'(mgain); @(posedge clk);
    cfg_idx <= CFG_NMDA_GAIN;  cfg_data <= WORD_W'(ngain); @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [WORD_W-1:0] rand_weight();
    case ($urandom_range(3))
      0:       return WORD_W'({$urandom, $urandom});
      1:       return WORD_W'($signed($urandom_range(8 << FRAC_W)) - (2 << FRAC_W));
      default: return WORD_W'($urandom_range(3 << FRAC_W));
    endcase
  endfunction

  // Ticks dominate so the neuron integrates, spikes and recovers.
  task automatic random_items(int n);
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if (sel < 60) send_item(REQ_TICK, WORD_W'({$urandom, $urandom}));
      else if (sel < 82) send_item(REQ_EXCIT, rand_weight());
      else send_item(REQ_INHIB, rand_weight());
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items at reset settings: field extremes and saturation.
    send_item(REQ_TICK, '0);
    send_item(REQ_EXCIT, WORD_MAX);
    send_item(REQ_EXCIT, WORD_MAX);
    send_item(REQ_TICK, '1);
    send_item(REQ_EXCIT, WORD_MIN);
    send_item(REQ_EXCIT, WORD_MIN);
    send_item(REQ_INHIB, WORD_MAX);
    send_item(REQ_TICK, '0);
    send_item(REQ_INHIB, WORD_MIN);
    send_item(REQ_INHIB, WORD_MIN);
    send_item(REQ_EXCIT, 40'd2 << FRAC_W);
    send_item(REQ_TICK, '0);
    send_item(REQ_TICK, '0);

    // Strong bias and gains above one: spike, refractory injections, zero refractory.
    write_regs(25'h1FFFFFF, 40'd20 << FRAC_W, 8'd3, 25'h1FFFFFF, 25'h1FFFFFF);
    send_item(REQ_TICK, '0);
    send_item(REQ_EXCIT, 40'd5 << FRAC_W);
    send_item(REQ_INHIB, 40'd5 << FRAC_W);
    repeat (4) send_item(REQ_TICK, '0);
    write_regs(25'd8388608, 40'd20 << FRAC_W, 8'd0, 25'd16777216, 25'd16777216);
    repeat (4) send_item(REQ_TICK, '0);
    random_items(160);

    write_regs(25'd0, WORD_MAX, 8'd255, 25'd0, 25'd0);
    random_items(60);
    write_regs(25'd16777216, WORD_MIN, 8'd255, 25'd16777216, 25'd0);
    random_items(80);

    write_regs(25'd3355443, 40'd3 << FRAC_W, 8'd2, 25'd1677722, 25'd167772);
    idle_en <= 1'b0;
    random_items(150);
    idle_en <= 1'b1;
    write_regs(25'($urandom), WORD_W'({$urandom, $urandom}), 8'($urandom),
               25'($urandom), 25'($urandom));
    random_items(60);
    write_regs(25'd3355443, 40'd1 << FRAC_W, 8'd1, 25'd3000000, 25'd100000);
    random_items(120);

    // Silence is permanent, so it comes last.
    send_item(REQ_SILENCE, WORD_W'({$urandom, $urandom}));
    send_item(REQ_TICK, '0);
    send_item(REQ_EXCIT, 40'd1 << FRAC_W);
    send_item(REQ_SILENCE, '1);
    send_item(REQ_TICK, '0);
    random_items(20);

    drain_block();
    if (fail_count == 0 && pending == 0) begin
      $display("conductance_lif_neuron_step_tb passed");
    end else begin
      $display("conductance_lif_neuron_step_tb failed");
    end
    $finish;
  end

endmodule

// ===== conductance_lif_neuron_step.f =====
+incdir+hdl
hdl/clif_pkg.sv
hdl/clif_mul.sv
hdl/clif_dpath.sv
hdl/clif_ctrl.sv
hdl/conductance_lif_neuron_step.sv
sim/conductance_lif_neuron_step_checker.sv
sim/conductance_lif_neuron_step_tb.sv
